// ===== hdl/ccsm_pkg.sv =====
// Package with the shared types and constants of the cell statistics map.
package ccsm_pkg;

    localparam int MapWidth  = 256;
    localparam int MapHeight = 256;
    localparam int CountBits = 24;
    localparam int Cells     = MapWidth * MapHeight;
    localparam int AddrBits  = $clog2(Cells);
    localparam int SumBits   = 32;
    localparam int SqBits    = 40;
    // Cell record: count, three sums, three sums of squares.
    localparam int CellBits  = CountBits + 3 * SumBits + 3 * SqBits;
    // Dividend width for the 40-bit square sum shifted left by 8.
    localparam int DivBits   = SqBits + 8;
    localparam int DivCntBits = $clog2(DivBits + 1);

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_QUERY   = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_SATURATED = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] cell_x;
        logic [9:0] cell_y;
        logic [7:0] channel_a;
        logic [7:0] channel_b;
        logic [7:0] channel_c;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] samples;
        logic [15:0] mean_a;
        logic [15:0] mean_b;
        logic [15:0] mean_c;
        logic [23:0] variance_a;
        logic [23:0] variance_b;
        logic [23:0] variance_c;
    } result_t;

    typedef struct packed {
        logic [CountBits-1:0] count;
        logic [SumBits-1:0]   sum_a;
        logic [SumBits-1:0]   sum_b;
        logic [SumBits-1:0]   sum_c;
        logic [SqBits-1:0]    sq_a;
        logic [SqBits-1:0]    sq_b;
        logic [SqBits-1:0]    sq_c;
    } cell_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQUARE,
        S_FINISH,
        S_OUTPUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sweep_write;
        logic capture_req;
        logic update;
        logic div_start;
        logic square;
        logic finish;
        logic out_load;
        logic out_clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic in_range;
        logic div_done;
        logic out_full;
    } stat_t;

endpackage

// ===== hdl/ccsm_ram.sv =====
// Generic single-port RAM with registered read data.
module ccsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/ccsm_div.sv =====
// Restoring radix-2 divider: six lanes (three means, three second moments), one divisor.
module ccsm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ccsm_pkg::CountBits-1:0]  divisor,
    input  logic [ccsm_pkg::DivBits-1:0]    dividend [6],
    output logic [ccsm_pkg::DivBits-1:0]    quotient [6],
    output logic                            done
);
    import ccsm_pkg::*;

    logic [DivBits-1:0]    quo_reg [6];
    logic [DivBits-1:0]    quo_next [6];
    logic [CountBits:0]    rem_reg [6];
    logic [CountBits:0]    rem_next [6];
    logic [CountBits-1:0]  dvs_reg;
    logic [DivCntBits-1:0] cnt_reg;
    logic [DivCntBits-1:0] cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;

    always_comb
    begin
        logic [CountBits+1:0] trial;
        trial = '0;
        for (int i = 0; i < 6; i++)
        begin
            quo_next[i] = quo_reg[i];
            rem_next[i] = rem_reg[i];
            if (busy_reg)
            begin
                trial = {rem_reg[i], quo_reg[i][DivBits-1]};
                quo_next[i] = {quo_reg[i][DivBits-2:0], 1'b0};
                if (trial >= {2'b00, dvs_reg})
                begin
                    trial = trial - {2'b00, dvs_reg};
                    quo_next[i][0] = 1'b1;
                end
                rem_next[i] = trial[CountBits:0];
            end
        end
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = DivCntBits'(DivBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCntBits'(1))
            begin
                // The last step lands at this edge; the quotients are final next cycle.
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            for (int i = 0; i < 6; i++)
            begin
                quo_reg[i] <= dividend[i];
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/ccsm_ctrl.sv =====
// Controller state machine: clearing sweep, request sequencing and result hand-off.
module ccsm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_stall,
    input  ccsm_pkg::stat_t stat,
    output ccsm_pkg::cmd_t  cmd,
    output logic            in_stall
);
    import ccsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:     if (stat.sweep_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:      state_next = stat.in_range ? S_UPDATE : S_OUTPUT;
            S_UPDATE:    state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (stat.div_done) state_next = S_SQUARE;
            S_SQUARE:    state_next = S_FINISH;
            S_FINISH:    state_next = S_OUTPUT;
            S_OUTPUT:    if (!stat.out_full) state_next = S_IDLE;
            default:     state_next = S_SWEEP;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_SWEEP:     cmd.sweep_write = 1'b1;
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.capture_req = in_valid;
            end
            S_READ:      in_stall = 1'b1;
            S_UPDATE:    cmd.update = 1'b1;
            S_DIV_START: cmd.div_start = 1'b1;
            S_DIV_WAIT:  in_stall = 1'b1;
            S_SQUARE:    cmd.square = 1'b1;
            S_FINISH:    cmd.finish = 1'b1;
            S_OUTPUT:    cmd.out_load = !stat.out_full;
            default:     cmd = '0;
        endcase
        cmd.out_clear = !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ccsm_dp.sv =====
// Datapath: cell store, update arithmetic, divider, variance and output register.
module ccsm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ccsm_pkg::cmd_t     cmd,
    input  ccsm_pkg::request_t req,
    output ccsm_pkg::stat_t    stat,
    output ccsm_pkg::result_t  result,
    output logic               valid
);
    import ccsm_pkg::*;

    request_t              req_reg;
    logic [AddrBits-1:0]   sweep_reg;
    logic [AddrBits-1:0]   addr;
    logic                  we;
    cell_t                 wcell;
    cell_t                 rcell;
    cell_t                 cell_reg;
    cell_t                 cell_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  in_range;
    logic [DivBits-1:0]    dvd [6];
    logic [DivBits-1:0]    quo [6];
    logic                  div_done;
    logic [15:0]           mean_reg [3];
    logic [DivBits-1:0]    e2_reg [3];
    logic [31:0]           msq_reg [3];
    logic [23:0]           var_reg [3];
    logic [23:0]           var_next [3];
    result_t               out_reg;
    logic                  out_valid_reg;
    logic [SumBits-1:0]    sums [3];
    logic [SqBits-1:0]     sqs [3];
    logic [CountBits-1:0]  divisor;

    assign in_range = (32'(req_reg.cell_x) < 32'(MapWidth))
                   && (32'(req_reg.cell_y) < 32'(MapHeight));

    assign addr = cmd.sweep_write ? sweep_reg
                : AddrBits'(32'(req_reg.cell_y) * 32'(MapWidth) + 32'(req_reg.cell_x));

    assign sums  = '{cell_reg.sum_a, cell_reg.sum_b, cell_reg.sum_c};
    assign sqs   = '{cell_reg.sq_a, cell_reg.sq_b, cell_reg.sq_c};

    // Read-modify-write of the addressed cell.
    always_comb
    begin
        cell_next   = rcell;
        status_next = ST_OK;
        unique case (op_t'(req_reg.op))
            OP_OBSERVE:
            begin
                if (rcell.count >= CountMax)
                begin
                    status_next = ST_SATURATED;
                end
                else
                begin
                    cell_next.count = rcell.count + 1'b1;
                    cell_next.sum_a = rcell.sum_a + SumBits'(req_reg.channel_a);
                    cell_next.sum_b = rcell.sum_b + SumBits'(req_reg.channel_b);
                    cell_next.sum_c = rcell.sum_c + SumBits'(req_reg.channel_c);
                    cell_next.sq_a  = rcell.sq_a
                        + SqBits'({8'h00, req_reg.channel_a} * {8'h00, req_reg.channel_a});
                    cell_next.sq_b  = rcell.sq_b
                        + SqBits'({8'h00, req_reg.channel_b} * {8'h00, req_reg.channel_b});
                    cell_next.sq_c  = rcell.sq_c
                        + SqBits'({8'h00, req_reg.channel_c} * {8'h00, req_reg.channel_c});
                end
            end
            OP_CLEAR:   cell_next = '0;
            OP_QUERY:   cell_next = rcell;
            OP_SPARE:   cell_next = rcell;
            default:    cell_next = rcell;
        endcase
    end

    assign we    = cmd.sweep_write || cmd.update;
    assign wcell = cmd.sweep_write ? '0 : cell_next;

    ccsm_ram #(.Width(CellBits), .Depth(Cells)) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wcell),
        .rdata (rcell)
    );

    assign divisor = (cell_reg.count == '0) ? CountBits'(1) : cell_reg.count;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvd[i]     = DivBits'({sums[i], 8'h00});
            dvd[i + 3] = {sqs[i], 8'h00};
        end
    end

    ccsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .dividend (dvd),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        logic [DivBits:0] diff;
        diff = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff = {1'b0, e2_reg[i]} - {1'b0, DivBits'(msq_reg[i][31:8])};
            var_next[i] = diff[DivBits] ? 24'd0 : diff[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_req)
        begin
            req_reg <= req;
        end
        if (cmd.update)
        begin
            cell_reg   <= cell_next;
            status_reg <= status_next;
        end
        if (div_done)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mean_reg[i] <= quo[i][15:0];
                e2_reg[i]   <= quo[i + 3];
            end
        end
        if (cmd.square)
        begin
            for (int i = 0; i < 3; i++)
            begin
                msq_reg[i] <= mean_reg[i] * mean_reg[i];
            end
        end
        if (cmd.finish)
        begin
            var_reg <= var_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cmd.sweep_write)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!in_range)
                begin
                    out_reg <= '{status: ST_RANGE, default: '0};
                end
                else
                begin
                    out_reg.status     <= status_reg;
                    out_reg.samples    <= 24'(cell_reg.count);
                    out_reg.mean_a     <= mean_reg[0];
                    out_reg.mean_b     <= mean_reg[1];
                    out_reg.mean_c     <= mean_reg[2];
                    out_reg.variance_a <= var_reg[0];
                    out_reg.variance_b <= var_reg[1];
                    out_reg.variance_c <= var_reg[2];
                end
            end
            else if (cmd.out_clear)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.sweep_done = cmd.sweep_write && (sweep_reg == AddrBits'(Cells - 1));
    assign stat.in_range   = in_range;
    assign stat.div_done   = div_done;
    assign stat.out_full   = out_valid_reg;
    assign result = out_reg;
    assign valid  = out_valid_reg;

endmodule

// ===== hdl/cell_color_statistics_map.sv =====
// Top level of the cell color statistics map: controller plus datapath.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------
//  request | in_valid    | in_stall    | in_data   (ccsm_pkg::request_t)
//  result  | out_valid   | out_stall   | out_data  (ccsm_pkg::result_t)
//
// After a request is accepted, its result is loaded into the output register
// after a store read, an update, a divider start, the 48 steps of the shared
// restoring divider, which hands over all six quotients at once, a squaring step,
// a variance step and the load; an out-of-range request goes from the store read
// to the load. A new request is taken in the cycle after the load, never before.
// After reset the block sweeps all 65536 cells to zero, one per cycle, and
// holds in_stall high for those cycles.
// While a finished result waits in the output register, the next request is
// still taken and processed; it holds in its last step until the register has
// been emptied.
module cell_color_statistics_map (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ccsm_pkg::request_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ccsm_pkg::result_t  out_data
);
    import ccsm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences each request through the datapath.
    ccsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    // The datapath holds the cell store and all arithmetic.
    ccsm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (in_data),
        .stat   (stat),
        .result (out_data),
        .valid  (out_valid)
    );

endmodule

// ===== dv/tb_cell_color_statistics_map.sv =====
// Self-checking testbench for the cell color statistics map.
module tb_cell_color_statistics_map;

    import ccsm_pkg::*;

    // The block serves one request at a time, and a clearing sweep of all 65536
    // cells follows reset. The limit below covers about 600 requests, each waiting
    // out the longest sender gap and receiver stall.
    localparam int  RandomRequests = 550;
    localparam int  SettleCycles   = 200;
    localparam real RunLimit       = 20.0 * (70000.0 + 600.0 * 400.0) * 4.0;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    request_t in_data;
    logic     out_valid;
    logic     out_stall;
    result_t  out_data;

    cell_color_statistics_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the cell store. Cells that are never touched are absent
    // from the arrays and read as zero.
    logic [23:0] shadow_count [int];
    logic [31:0] shadow_sum   [int][3];
    logic [39:0] shadow_sq    [int][3];

    request_t pending_requests [$];
    result_t  expected_results [$];
    int       error_count;
    bit       stimulus_done;

    // Controls shared by the driver, the receiver stall process and the stimulus process.
    bit       quiet_mode;    // no random idling on either side
    int       stall_stretch; // receiver holds off for this many cycles

    // Mean is 8.8 and variance is 16.8 fixed point. The count is floored at 1.
    function automatic void channel_stats(input logic [31:0] sum, input logic [39:0] sq,
                                          input logic [23:0] count,
                                          output logic [15:0] mean,
                                          output logic [23:0] variance);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] e2;
        logic [63:0] m2;
        n        = (count == 0) ? 64'd1 : 64'(count);
        m        = (64'(sum) << 8) / n;
        e2       = (64'(sq) << 8) / n;
        m2       = (m * m) >> 8;
        mean     = m[15:0];
        variance = (e2 > m2) ? 24'(e2 - m2) : 24'd0;
    endfunction

    // Applies one request to the shadow store and returns the result it yields.
    function automatic result_t apply_to_cells(input request_t req);
        result_t     res;
        int          idx;
        logic [7:0]  pixel [3];
        logic [15:0] mean_v [3];
        logic [23:0] var_v [3];
        res = '0;
        if (req.cell_x >= MapWidth || req.cell_y >= MapHeight)
        begin
            res.status = ST_RANGE;
            return res;
        end
        idx   = int'(req.cell_x) + MapWidth * int'(req.cell_y);
        pixel = '{req.channel_a, req.channel_b, req.channel_c};
        if (!shadow_count.exists(idx))
        begin
            shadow_count[idx] = '0;
            for (int k = 0; k < 3; k++)
            begin
                shadow_sum[idx][k] = '0;
                shadow_sq[idx][k]  = '0;
            end
        end
        res.status = ST_OK;
        if (op_t'(req.op) == OP_OBSERVE)
        begin
            if (shadow_count[idx] == CountMax)
                res.status = ST_SATURATED;
            else
            begin
                shadow_count[idx] = shadow_count[idx] + 1;
                for (int k = 0; k < 3; k++)
                begin
                    shadow_sum[idx][k] = shadow_sum[idx][k] + pixel[k];
                    shadow_sq[idx][k]  = shadow_sq[idx][k] + 40'(pixel[k]) * pixel[k];
                end
            end
        end
        else if (op_t'(req.op) == OP_CLEAR)
        begin
            shadow_count[idx] = '0;
            for (int k = 0; k < 3; k++)
            begin
                shadow_sum[idx][k] = '0;
                shadow_sq[idx][k]  = '0;
            end
        end
        for (int k = 0; k < 3; k++)
            channel_stats(shadow_sum[idx][k], shadow_sq[idx][k], shadow_count[idx],
                          mean_v[k], var_v[k]);
        res.samples    = shadow_count[idx];
        res.mean_a     = mean_v[0];
        res.mean_b     = mean_v[1];
        res.mean_c     = mean_v[2];
        res.variance_a = var_v[0];
        res.variance_b = var_v[1];
        res.variance_c = var_v[2];
        return res;
    endfunction

    function automatic request_t make_request(input op_t op, input int x, input int y,
                                              input int a, input int b, input int c);
        request_t req;
        req.op        = op;
        req.cell_x    = 10'(x);
        req.cell_y    = 10'(y);
        req.channel_a = 8'(a);
        req.channel_b = 8'(b);
        req.channel_c = 8'(c);
        return req;
    endfunction

    // Driver. Inputs change on the falling edge. A request counts as accepted
    // when valid was high and stall low at the preceding rising edge, which
    // is what the flag sampled there records.
    bit accepted_at_rise;

    always @(posedge clk)
        accepted_at_rise <= in_valid && !in_stall && rst_n;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (accepted_at_rise)
            begin
                // The prediction runs in order of acceptance.
                expected_results.push_back(apply_to_cells(in_data));
                void'(pending_requests.pop_front());
            end
            // Once offered, a request stays until it is taken.
            if (!in_valid || accepted_at_rise)
            begin
                if (pending_requests.size() != 0 &&
                    (quiet_mode || $urandom_range(99) >= 19))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Results are compared at the rising edge where they are taken.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: %p", out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    error_count++;
                end
                if (out_data.samples !== want.samples)
                begin
                    $error("samples: expected %0d, got %0d", want.samples, out_data.samples);
                    error_count++;
                end
                if (out_data.mean_a !== want.mean_a)
                begin
                    $error("mean_a: expected %0d, got %0d", want.mean_a, out_data.mean_a);
                    error_count++;
                end
                if (out_data.mean_b !== want.mean_b)
                begin
                    $error("mean_b: expected %0d, got %0d", want.mean_b, out_data.mean_b);
                    error_count++;
                end
                if (out_data.mean_c !== want.mean_c)
                begin
                    $error("mean_c: expected %0d, got %0d", want.mean_c, out_data.mean_c);
                    error_count++;
                end
                if (out_data.variance_a !== want.variance_a)
                begin
                    $error("variance_a: expected %0d, got %0d",
                           want.variance_a, out_data.variance_a);
                    error_count++;
                end
                if (out_data.variance_b !== want.variance_b)
                begin
                    $error("variance_b: expected %0d, got %0d",
                           want.variance_b, out_data.variance_b);
                    error_count++;
                end
                if (out_data.variance_c !== want.variance_c)
                begin
                    $error("variance_c: expected %0d, got %0d",
                           want.variance_c, out_data.variance_c);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall. A long hold-off is counted down here, in its own process.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_stretch > 0)
        begin
            out_stall     <= 1'b1;
            stall_stretch <= stall_stretch - 1;
        end
        else
            out_stall <= !quiet_mode && ($urandom_range(99) < 19);
    end

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Random request. Most land on a small patch of cells so that statistics
    // build up; a few hit any cell, out-of-range coordinates, or the spare op.
    function automatic request_t random_request();
        int  pick;
        op_t op;
        int  x;
        int  y;
        pick = $urandom_range(99);
        if (pick < 65)
            op = OP_OBSERVE;
        else if (pick < 85)
            op = OP_QUERY;
        else if (pick < 95)
            op = OP_CLEAR;
        else
            op = OP_SPARE;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            x = $urandom_range(3);
            y = $urandom_range(3);
        end
        else if (pick < 92)
        begin
            x = $urandom_range(MapWidth - 1);
            y = $urandom_range(MapHeight - 1);
        end
        else
        begin
            x = $urandom_range(1023);
            y = $urandom_range(1023);
        end
        return make_request(op, x, y, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255));
    endfunction

    initial
    begin
        error_count   = 0;
        stimulus_done = 1'b0;
        quiet_mode    = 1'b0;
        stall_stretch = 0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty cells, corners, channel extremes, every op,
        // out-of-range on each axis and at the top of the coordinate field.
        pending_requests.push_back(make_request(OP_QUERY, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_OBSERVE, 0, 0, 255, 255, 255));
        pending_requests.push_back(make_request(OP_OBSERVE, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_OBSERVE, 0, 0, 255, 0, 128));
        pending_requests.push_back(make_request(OP_QUERY, 0, 0, 17, 33, 99));
        pending_requests.push_back(make_request(OP_SPARE, 0, 0, 255, 255, 255));
        pending_requests.push_back(make_request(OP_OBSERVE, 255, 255, 170, 85, 1));
        pending_requests.push_back(make_request(OP_OBSERVE, 255, 255, 85, 170, 254));
        pending_requests.push_back(make_request(OP_QUERY, 255, 255, 0, 0, 0));
        pending_requests.push_back(make_request(OP_OBSERVE, 256, 0, 1, 2, 3));
        pending_requests.push_back(make_request(OP_OBSERVE, 0, 256, 1, 2, 3));
        pending_requests.push_back(make_request(OP_CLEAR, 1023, 1023, 255, 255, 255));
        pending_requests.push_back(make_request(OP_QUERY, 1023, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_QUERY, 682, 341, 0, 0, 0));
        pending_requests.push_back(make_request(OP_CLEAR, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_QUERY, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_OBSERVE, 0, 0, 200, 100, 50));
        pending_requests.push_back(make_request(OP_CLEAR, 128, 64, 0, 0, 0));
        pending_requests.push_back(make_request(OP_OBSERVE, 341, 682, 255, 255, 255));
        wait_for_drain();

        // Stretch without idling, then a long receiver hold-off while the
        // sender keeps offering, so the block backs up and stalls its input.
        quiet_mode = 1'b1;
        for (int i = 0; i < 60; i++)
            pending_requests.push_back(random_request());
        wait_for_drain();
        stall_stretch = 400;
        for (int i = 0; i < 20; i++)
            pending_requests.push_back(random_request());
        wait_for_drain();
        quiet_mode = 1'b0;

        // Random traffic in chunks. After some chunks the sender pauses
        // until every result is back.
        for (int chunk = 0; chunk < 10; chunk++)
        begin
            for (int i = 0; i < (RandomRequests - 80) / 10; i++)
                pending_requests.push_back(random_request());
            if (chunk % 3 == 2)
                wait_for_drain();
            else
                while (pending_requests.size() > 4)
                    @(posedge clk);
        end
        wait_for_drain();
        repeat (SettleCycles) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(RunLimit);
        $display("status: fail");
        $finish;
    end

endmodule
